@@ hw/rtl/latps_pkg.sv @@
// ----------------------------------------------------------------------------
// latps_pkg
// Shared types and constants of the transmit port selector.
// ----------------------------------------------------------------------------
package latps_pkg;

    // Input word modes
    localparam logic [1:0] MODE_SELECT  = 2'd0;
    localparam logic [1:0] MODE_ENABLE  = 2'd1;
    localparam logic [1:0] MODE_DISABLE = 2'd2;

    localparam logic [15:0] LLDP_TYPE = 16'h88CC;
    localparam logic [7:0]  HASH_MOD  = 8'd251;

    // Remainder unit: 32-bit dividend, one byte per cycle
    localparam int          MOD_DVD_W   = 32;
    localparam int          MOD_CHUNK_W = 8;
    localparam logic [1:0]  MOD_LAST_WORD = 2'd3;
    localparam logic [1:0]  MOD_LAST_BYTE = 2'd0;

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  port_id;
        logic [47:0] port_address;
        logic        port_attached;
        logic [4:0]  ring_count;
        logic [31:0] flow_hash;
        logic [15:0] ether_type;
        logic [47:0] source_address;
        logic [31:0] ring_hint;
    } t_in_word;

    typedef struct packed {
        logic       selected;
        logic       dropped;
        logic [2:0] out_port;
        logic [3:0] out_ring;
        logic [3:0] active_ports;
    } t_out_word;

    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_ENABLE,
        CMD_DISABLE,
        CMD_SELECT
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic        lldp;
        logic [2:0]  port_id;
        logic [47:0] port_address;
        logic [4:0]  ring_count;
        logic [31:0] flow_hash;
        logic [47:0] source_address;
        logic [31:0] ring_hint;
    } t_cmd;

    typedef struct packed {
        logic                 start;
        logic [MOD_DVD_W-1:0] dividend;
        logic [7:0]           divisor;
        logic [1:0]           last;
    } t_mod_req;

    typedef struct packed {
        logic       busy;
        logic       done;
        logic [7:0] rem;
    } t_mod_rsp;

endpackage

@@ hw/rtl/latps_in_if.sv @@
// ----------------------------------------------------------------------------
// latps_in_if
// Input channel: valid/ready handshake carrying one input word.
// ----------------------------------------------------------------------------
interface latps_in_if import latps_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/latps_out_if.sv @@
// ----------------------------------------------------------------------------
// latps_out_if
// Result channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface latps_out_if import latps_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/latps_front.sv @@
// ----------------------------------------------------------------------------
// latps_front
// Accept input words and classify them into back-end commands.
// ----------------------------------------------------------------------------
module latps_front import latps_pkg::*; #(
    parameter int NUM_PORTS = 8,
    parameter int MAX_RINGS = 16
) (
    latps_in_if.sink i_in,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_ready
);

    logic       pid_ok;
    logic [4:0] rc_sat;
    t_cmd_kind  kind;

    assign i_in.ready  = i_cmd_ready;
    assign o_cmd_valid = i_in.valid;

    assign pid_ok = (6'(i_in.payload.port_id) < 6'(NUM_PORTS));

    // saturate ring count to the supported maximum
    always_comb begin
        rc_sat = i_in.payload.ring_count;
        if (7'(i_in.payload.ring_count) > 7'(MAX_RINGS)) begin
            rc_sat = 5'(MAX_RINGS);
        end
    end

    always_comb begin
        case (i_in.payload.mode)
            MODE_SELECT:  kind = CMD_SELECT;
            MODE_ENABLE:  kind = (pid_ok && i_in.payload.port_attached) ? CMD_ENABLE : CMD_NOP;
            MODE_DISABLE: kind = pid_ok ? CMD_DISABLE : CMD_NOP;
            default:      kind = CMD_NOP;
        endcase
    end

    always_comb begin
        o_cmd.kind           = kind;
        o_cmd.lldp           = (i_in.payload.ether_type == LLDP_TYPE);
        o_cmd.port_id        = i_in.payload.port_id;
        o_cmd.port_address   = i_in.payload.port_address;
        o_cmd.ring_count     = rc_sat;
        o_cmd.flow_hash      = i_in.payload.flow_hash;
        o_cmd.source_address = i_in.payload.source_address;
        o_cmd.ring_hint      = i_in.payload.ring_hint;
    end

endmodule

@@ hw/rtl/latps_cmdq.sv @@
// ----------------------------------------------------------------------------
// latps_cmdq
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module latps_cmdq import latps_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_din,
    output logic o_wr_ready,
    output logic o_rd_valid,
    output t_cmd o_dout,
    input  logic i_pop
);

    t_cmd               r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [CMDQ_CW-1:0] r_cnt, n_cnt;
    logic               wr, rd;

    assign o_wr_ready = (r_cnt != CMDQ_CW'(CMDQ_DEPTH));
    assign o_rd_valid = (r_cnt != '0);
    assign o_dout     = r_mem[r_rp];

    assign wr = i_push && o_wr_ready;
    assign rd = i_pop && o_rd_valid;

    always_comb begin
        n_wp  = wr ? r_wp + CMDQ_AW'(1) : r_wp;
        n_rp  = rd ? r_rp + CMDQ_AW'(1) : r_rp;
        n_cnt = r_cnt + CMDQ_CW'(wr) - CMDQ_CW'(rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_din;
        end
    end

endmodule

@@ hw/rtl/latps_mod.sv @@
// ----------------------------------------------------------------------------
// latps_mod
// Iterative remainder unit, eight dividend bits per cycle, 8-bit divisor.
// ----------------------------------------------------------------------------
module latps_mod import latps_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mod_req i_req,
    output t_mod_rsp o_rsp
);

    logic                 r_busy, r_done;
    logic [7:0]           r_rem, n_rem;
    logic [7:0]           r_div;
    logic [MOD_DVD_W-1:0] r_dvd;
    logic [1:0]           r_left;

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

    // restoring steps over the top byte; remainder stays below the divisor
    always_comb begin
        logic [8:0] t;
        logic [7:0] r;
        r = r_rem;
        t = '0;
        for (int i = MOD_CHUNK_W - 1; i >= 0; i--) begin
            t = {r, r_dvd[MOD_DVD_W-MOD_CHUNK_W+i]};
            if (t >= {1'b0, r_div}) begin
                t = t - {1'b0, r_div};
            end
            r = t[7:0];
        end
        n_rem = r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_left == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_dvd  <= i_req.dividend;
            r_div  <= i_req.divisor;
            r_left <= i_req.last;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_dvd  <= r_dvd << MOD_CHUNK_W;
            r_left <= r_left - 2'd1;
        end
    end

endmodule

@@ hw/rtl/latps_back.sv @@
// ----------------------------------------------------------------------------
// latps_back
// Execute commands against the port table and register the result word.
// ----------------------------------------------------------------------------
module latps_back import latps_pkg::*; #(
    parameter int NUM_PORTS = 8,
    parameter int MAX_RINGS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_ready,
    output t_mod_req  o_mod_req,
    input  t_mod_rsp  i_mod_rsp,
    latps_out_if.source o_out
);

    localparam int PW  = $clog2(NUM_PORTS);
    localparam int CW  = $clog2(NUM_PORTS + 1);
    localparam int RCW = (MAX_RINGS < 31) ? $clog2(MAX_RINGS + 1) : 5;

    typedef enum logic [9:0] {
        S_IDLE      = 10'b0000000001,
        S_EXEC      = 10'b0000000010,
        S_DIS       = 10'b0000000100,
        S_LLDP_CMP  = 10'b0000001000,
        S_LLDP_PICK = 10'b0000010000,
        S_HASH      = 10'b0000100000,
        S_SLOT      = 10'b0001000000,
        S_RING      = 10'b0010000000,
        S_RWAIT     = 10'b0100000000,
        S_OUT       = 10'b1000000000
    } t_back_state;

    t_back_state     r_state, n_state;

    logic [PW-1:0]   r_slot_port  [NUM_PORTS];
    logic [PW-1:0]   r_port_slot  [NUM_PORTS];
    logic [47:0]     r_port_mac   [NUM_PORTS];
    logic [RCW-1:0]  r_port_rings [NUM_PORTS];
    logic [NUM_PORTS-1:0] r_port_en, r_port_known, r_match;
    logic [CW-1:0]   r_active, n_active;

    t_cmd            r_cmd;
    logic [PW-1:0]   r_p, n_p;
    logic [PW-1:0]   r_idx, r_last;
    t_out_word       r_res, n_res;
    t_out_word       r_out, n_out;
    logic            r_out_valid, n_out_valid;
    logic [15:0]     r_hfold;

    logic [PW-1:0]   pid, moved, first_hit;
    logic [RCW-1:0]  rc;
    logic            take, en_wr, dis_wr;
    logic [10:0]     hfold2;
    logic [8:0]      hfold3;
    logic [7:0]      hash_mod;

    function automatic t_out_word make_res(logic sel, logic drop, logic [PW-1:0] port,
                                           logic [3:0] ring, logic [CW-1:0] act);
        t_out_word w;
        w.selected     = sel;
        w.dropped      = drop;
        w.out_port     = 3'(port);
        w.out_ring     = ring;
        w.active_ports = 4'(act);
        return w;
    endfunction

    assign o_cmd_ready   = (r_state == S_IDLE);
    assign take          = i_cmd_valid && o_cmd_ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    assign pid   = PW'(r_cmd.port_id);
    assign moved = r_slot_port[r_last];
    assign rc    = r_port_rings[r_p];

    // 2^8 is 5 modulo 251: fold the upper byte down twice, then one subtract
    always_comb begin
        hfold2   = 11'(r_hfold[15:8]) * 11'd5 + 11'(r_hfold[7:0]);
        hfold3   = 9'(hfold2[10:8]) * 9'd5 + 9'(hfold2[7:0]);
        hash_mod = (hfold3 >= 9'(HASH_MOD)) ? 8'(hfold3 - 9'(HASH_MOD)) : hfold3[7:0];
    end

    // lowest matching port wins
    always_comb begin
        first_hit = '0;
        for (int i = NUM_PORTS - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                first_hit = PW'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_p         = r_p;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        en_wr       = 1'b0;
        dis_wr      = 1'b0;
        o_mod_req   = '0;

        case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_cmd.kind)
                    CMD_ENABLE: begin
                        if (!r_port_en[pid] && (r_active < CW'(NUM_PORTS))) begin
                            en_wr    = 1'b1;
                            n_active = r_active + CW'(1);
                        end
                        n_res   = make_res(1'b0, 1'b0, '0, 4'd0, n_active);
                        n_state = S_OUT;
                    end
                    CMD_DISABLE: begin
                        if (r_port_en[pid]) begin
                            n_state = S_DIS;
                        end else begin
                            n_res   = make_res(1'b0, 1'b0, '0, 4'd0, r_active);
                            n_state = S_OUT;
                        end
                    end
                    CMD_SELECT: begin
                        if (r_active == '0) begin
                            n_res   = make_res(1'b0, 1'b1, '0, 4'd0, r_active);
                            n_state = S_OUT;
                        end else if (r_cmd.lldp) begin
                            n_state = S_LLDP_CMP;
                        end else begin
                            n_state = S_HASH;
                        end
                    end
                    default: begin
                        n_res   = make_res(1'b0, 1'b0, '0, 4'd0, r_active);
                        n_state = S_OUT;
                    end
                endcase
            end
            S_DIS: begin
                dis_wr   = 1'b1;
                n_active = r_active - CW'(1);
                n_res    = make_res(1'b0, 1'b0, '0, 4'd0, n_active);
                n_state  = S_OUT;
            end
            S_LLDP_CMP: begin
                n_state = S_LLDP_PICK;
            end
            S_LLDP_PICK: begin
                if (r_match == '0) begin
                    n_res   = make_res(1'b0, 1'b1, '0, 4'd0, r_active);
                    n_state = S_OUT;
                end else begin
                    n_p     = first_hit;
                    n_state = S_RING;
                end
            end
            S_HASH: begin
                o_mod_req.start    = 1'b1;
                o_mod_req.dividend = {hash_mod, (MOD_DVD_W - MOD_CHUNK_W)'(0)};
                o_mod_req.divisor  = 8'(r_active);
                o_mod_req.last     = MOD_LAST_BYTE;
                n_state            = S_SLOT;
            end
            S_SLOT: begin
                if (i_mod_rsp.done) begin
                    n_p     = r_slot_port[PW'(i_mod_rsp.rem)];
                    n_state = S_RING;
                end
            end
            S_RING: begin
                if (rc > RCW'(1)) begin
                    o_mod_req.start    = 1'b1;
                    o_mod_req.dividend = r_cmd.ring_hint;
                    o_mod_req.divisor  = 8'(rc);
                    o_mod_req.last     = MOD_LAST_WORD;
                    n_state            = S_RWAIT;
                end else begin
                    n_res   = make_res(1'b1, 1'b0, r_p, 4'd0, r_active);
                    n_state = S_OUT;
                end
            end
            S_RWAIT: begin
                if (i_mod_rsp.done) begin
                    n_res   = make_res(1'b1, 1'b0, r_p, 4'(i_mod_rsp.rem), r_active);
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state and tables with a defined reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_active     <= '0;
            r_out_valid  <= 1'b0;
            r_port_en    <= '0;
            r_port_known <= '0;
            for (int i = 0; i < NUM_PORTS; i++) begin
                r_port_slot[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
            if (en_wr) begin
                r_port_slot[pid]  <= PW'(r_active);
                r_port_en[pid]    <= 1'b1;
                r_port_known[pid] <= 1'b1;
            end
            if (dis_wr) begin
                if (r_idx != r_last) begin
                    r_port_slot[moved] <= r_idx;
                end
                r_port_slot[pid] <= '0;
                r_port_en[pid]   <= 1'b0;
            end
        end
    end

    // payload and tables that hold nothing until written
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= i_cmd;
        end
        if ((r_state == S_EXEC) && (r_cmd.kind == CMD_DISABLE)) begin
            r_idx  <= r_port_slot[pid];
            r_last <= PW'(r_active - CW'(1));
        end
        if (en_wr) begin
            r_slot_port[PW'(r_active)] <= pid;
            r_port_mac[pid]            <= r_cmd.port_address;
            r_port_rings[pid]          <= RCW'(r_cmd.ring_count);
        end
        if (dis_wr && (r_idx != r_last)) begin
            r_slot_port[r_idx] <= moved;
        end
        for (int i = 0; i < NUM_PORTS; i++) begin
            r_match[i] <= r_port_known[i] && (r_port_mac[i] == r_cmd.source_address);
        end
        // first fold of the hash bytes, weights 2^24, 2^16, 2^8 modulo 251
        r_hfold <= 16'(r_cmd.flow_hash[31:24]) * 16'd125
                 + 16'(r_cmd.flow_hash[23:16]) * 16'd25
                 + 16'(r_cmd.flow_hash[15:8]) * 16'd5
                 + 16'(r_cmd.flow_hash[7:0]);
        r_p   <= n_p;
        r_res <= n_res;
        r_out <= n_out;
    end

    a_active_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active <= CW'(NUM_PORTS))
        else $error("active count above table size");

    a_active_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_port_en) == int'(r_active))
        else $error("enabled flags disagree with active count");

    a_enabled_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_port_en & ~r_port_known) == '0)
        else $error("enabled port not recorded");

    a_mod_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mod_req.start |-> !i_mod_rsp.busy)
        else $error("remainder unit started while busy");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && (!r_out_valid || o_out.ready)) |=> o_out.valid)
        else $error("finished result not presented");

endmodule

@@ hw/rtl/link_aggregation_tx_port_select_core.sv @@
// ----------------------------------------------------------------------------
// link_aggregation_tx_port_select_core
// The back end takes one word at a time and finishes it before it accepts the
// next; its pace is set by the back-end sequencer and its shared remainder
// unit, which retires eight dividend bits per cycle. The command queue lets the
// input side keep accepting words meanwhile while it has room.
// Reset: synchronous, active low; clears the table flags, slot map, count and
// queue at once, no clearing pass. Address, ring and slot stores hold no reset.
// ----------------------------------------------------------------------------
module link_aggregation_tx_port_select_core import latps_pkg::*; #(
    parameter int NUM_PORTS = 8,
    parameter int MAX_RINGS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    latps_in_if.sink    i_in,
    latps_out_if.source o_out
);

    // Front to queue: classified command words
    logic     fq_valid, fq_ready;
    t_cmd     fq_cmd;

    // Queue to back end
    logic     qb_valid, qb_ready;
    t_cmd     qb_cmd;

    // Back end to remainder unit
    t_mod_req mod_req;
    t_mod_rsp mod_rsp;

    // Front: decode mode, range check the port id, saturate the ring count,
    // flag LLDP frames. Table state is left to the back end, since queued
    // commands ahead of this word may still change it.
    latps_front #(
        .NUM_PORTS (NUM_PORTS),
        .MAX_RINGS (MAX_RINGS)
    ) u_front (
        .i_in        (i_in),
        .o_cmd_valid (fq_valid),
        .o_cmd       (fq_cmd),
        .i_cmd_ready (fq_ready)
    );

    // Queue: hold classified words so the input side keeps accepting while
    // the back end grinds through a remainder.
    latps_cmdq u_cmdq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (fq_valid),
        .i_din      (fq_cmd),
        .o_wr_ready (fq_ready),
        .o_rd_valid (qb_valid),
        .o_dout     (qb_cmd),
        .i_pop      (qb_ready)
    );

    // Shared remainder unit: folded hash mod active count, then ring hint
    // mod ring count. The hash mod 251 is folded in the back end itself.
    latps_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    // Back end: one command at a time against the port table; the result
    // waits in an output register so the next command can start.
    latps_back #(
        .NUM_PORTS (NUM_PORTS),
        .MAX_RINGS (MAX_RINGS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (qb_valid),
        .i_cmd       (qb_cmd),
        .o_cmd_ready (qb_ready),
        .o_mod_req   (mod_req),
        .i_mod_rsp   (mod_rsp),
        .o_out       (o_out)
    );

endmodule
